/* hw/rtl/json_string_unescape_unit_assert.svh */
// Assertion macros used by the checker of the JSON string unescape unit.
`ifndef JSON_STRING_UNESCAPE_UNIT_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/jsu_pkg.sv */
// Types, constants and helper functions of the JSON string unescape unit.
package jsu_pkg;

  // Default width of the internal source byte counter.
  localparam int unsigned CountWidth    = 16;
  // Width of the consumed length reported with a done word.
  localparam int unsigned ConsumedWidth = 16;

  // Source characters with a meaning of their own.
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharLowerB    = 8'h62;
  localparam logic [7:0] CharLowerF    = 8'h66;
  localparam logic [7:0] CharLowerN    = 8'h6E;
  localparam logic [7:0] CharLowerR    = 8'h72;
  localparam logic [7:0] CharLowerT    = 8'h74;
  localparam logic [7:0] CharLowerU    = 8'h75;

  // Control bytes produced by the short escapes.
  localparam logic [7:0] CtrlBackspace = 8'h08;
  localparam logic [7:0] CtrlFormFeed  = 8'h0C;
  localparam logic [7:0] CtrlNewline   = 8'h0A;
  localparam logic [7:0] CtrlReturn    = 8'h0D;
  localparam logic [7:0] CtrlTab       = 8'h09;

  // UTF-8 encoding limits and prefixes.
  localparam logic [15:0] Utf8TwoByteMin   = 16'h0080;
  localparam logic [15:0] Utf8ThreeByteMin = 16'h0800;
  localparam logic [7:0]  Utf8Lead2        = 8'hC0;
  localparam logic [7:0]  Utf8Lead3        = 8'hE0;
  localparam logic [7:0]  Utf8Cont         = 8'h80;
  localparam logic [5:0]  Utf8ContMask     = 6'h3F;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_DONE     = 3'd1,
    KIND_BAD_HEX  = 3'd2,
    KIND_UNTERM   = 3'd3,
    KIND_NO_QUOTE = 3'd4
  } kind_e;

  // Decoder phases.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BODY,
    PH_ESC,
    PH_HEX,
    PH_DISCARD
  } phase_e;

  // Input word.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       source_end;
  } in_word_t;

  // Output word.
  typedef struct packed {
    logic [7:0]               out_byte;
    kind_e                    kind;
    logic [ConsumedWidth-1:0] consumed;
    logic                     last;
  } out_word_t;

  // All results caused by one source byte: up to three data bytes, then an
  // optional closing word (done or an error).
  typedef struct packed {
    logic [2:0][7:0]          data;
    logic [1:0]               n_data;
    logic                     has_tail;
    kind_e                    tail_kind;
    logic [ConsumedWidth-1:0] consumed;
  } bundle_t;

  // Hex digit decode: bit 4 is set for a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] res;
    res = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      res = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      res = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      res = {1'b1, 4'(c - 8'h57)};
    end
    return res;
  endfunction

  // Number of output words in a bundle.
  function automatic logic [2:0] bundle_len(input bundle_t b);
    return {1'b0, b.n_data} + {2'b00, b.has_tail};
  endfunction

endpackage

/* hw/rtl/jsu_stream_if.sv */
// Valid/ready stream interface carrying one payload word per handshake.
interface jsu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/jsu_decoder.sv */
// Escape decoder: parser state and the result bundle for each accepted byte.
module jsu_decoder #(
  parameter int unsigned COUNT_WIDTH = jsu_pkg::CountWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  jsu_pkg::in_word_t word_i,
  output jsu_pkg::bundle_t  bundle_o
);
  import jsu_pkg::*;

  localparam int unsigned ExtWidth =
    (COUNT_WIDTH > ConsumedWidth) ? COUNT_WIDTH : ConsumedWidth;

  phase_e                 phase_q, phase_d;
  logic [1:0]             hex_count_q, hex_count_d;
  logic [15:0]            code_point_q, code_point_d;
  logic [COUNT_WIDTH-1:0] byte_count_q, byte_count_d;

  logic [7:0]             c;
  logic                   src_end;
  logic                   is_quote;
  logic                   is_bs;
  logic [4:0]             hex;
  logic [15:0]            cp_next;
  logic                   last_digit;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [ExtWidth-1:0]    count_ext;
  logic [ConsumedWidth-1:0] consumed;
  logic                   open;

  // Shared decode of the incoming byte.
  assign c          = word_i.in_byte;
  assign src_end    = word_i.source_end;
  assign is_quote   = (c == CharQuote);
  assign is_bs      = (c == CharBackslash);
  assign hex        = hex_digit(c);
  assign cp_next    = {code_point_q[11:0], hex[3:0]};
  assign last_digit = (hex_count_q == 2'd3);

  // Saturating byte counter and the consumed length clipped to its field.
  assign count_inc = (byte_count_q == '1) ? byte_count_q : byte_count_q + 1'b1;
  assign count_ext = ExtWidth'(count_inc);
  assign consumed  = (count_ext > ExtWidth'(16'hFFFF)) ? '1
                                                        : count_ext[ConsumedWidth-1:0];

  // The string stays open after this byte unless it closes or fails here.
  always_comb begin
    open = 1'b0;
    case (phase_q)
      PH_IDLE: open = is_quote;
      PH_BODY: open = !is_quote;
      PH_ESC:  open = 1'b1;
      PH_HEX:  open = hex[4];
      default: open = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    phase_d      = phase_q;
    hex_count_d  = hex_count_q;
    code_point_d = code_point_q;
    byte_count_d = byte_count_q;
    case (phase_q)
      PH_IDLE: begin
        if (is_quote) begin
          byte_count_d = COUNT_WIDTH'(1);
          phase_d      = PH_BODY;
        end else begin
          phase_d = PH_DISCARD;
        end
      end
      PH_BODY: begin
        byte_count_d = count_inc;
        if (is_quote) begin
          phase_d = PH_DISCARD;
        end else if (is_bs) begin
          phase_d = PH_ESC;
        end
      end
      PH_ESC: begin
        byte_count_d = count_inc;
        if (c == CharLowerU) begin
          phase_d      = PH_HEX;
          hex_count_d  = 2'd0;
          code_point_d = 16'h0000;
        end else begin
          phase_d = PH_BODY;
        end
      end
      PH_HEX: begin
        byte_count_d = count_inc;
        if (!hex[4]) begin
          phase_d = PH_DISCARD;
        end else begin
          code_point_d = cp_next;
          if (last_digit) begin
            hex_count_d = 2'd0;
            phase_d     = PH_BODY;
          end else begin
            hex_count_d = hex_count_q + 2'd1;
          end
        end
      end
      default: begin
        phase_d = PH_DISCARD;
      end
    endcase
    // The end of the source always returns the parser to idle.
    if (src_end) begin
      phase_d     = PH_IDLE;
      hex_count_d = 2'd0;
    end
  end

  // Result bundle: data bytes first, then the closing word if any.
  always_comb begin
    bundle_o = '0;
    case (phase_q)
      PH_IDLE: begin
        if (!is_quote) begin
          bundle_o.has_tail  = 1'b1;
          bundle_o.tail_kind = KIND_NO_QUOTE;
        end
      end
      PH_BODY: begin
        if (is_quote) begin
          bundle_o.has_tail  = 1'b1;
          bundle_o.tail_kind = KIND_DONE;
          bundle_o.consumed  = consumed;
        end else if (!is_bs) begin
          bundle_o.data[0] = c;
          bundle_o.n_data  = 2'd1;
        end
      end
      PH_ESC: begin
        bundle_o.n_data = 2'd1;
        case (c)
          CharLowerB: bundle_o.data[0] = CtrlBackspace;
          CharLowerF: bundle_o.data[0] = CtrlFormFeed;
          CharLowerN: bundle_o.data[0] = CtrlNewline;
          CharLowerR: bundle_o.data[0] = CtrlReturn;
          CharLowerT: bundle_o.data[0] = CtrlTab;
          CharLowerU: bundle_o.n_data  = 2'd0;
          default:    bundle_o.data[0] = c;
        endcase
      end
      PH_HEX: begin
        if (!hex[4]) begin
          bundle_o.has_tail  = 1'b1;
          bundle_o.tail_kind = KIND_BAD_HEX;
        end else if (last_digit) begin
          // UTF-8 encode the gathered code point on its own.
          if (cp_next < Utf8TwoByteMin) begin
            bundle_o.data[0] = cp_next[7:0];
            bundle_o.n_data  = 2'd1;
          end else if (cp_next < Utf8ThreeByteMin) begin
            bundle_o.data[0] = Utf8Lead2 | {3'b000, cp_next[10:6]};
            bundle_o.data[1] = Utf8Cont | {2'b00, cp_next[5:0] & Utf8ContMask};
            bundle_o.n_data  = 2'd2;
          end else begin
            bundle_o.data[0] = Utf8Lead3 | {4'b0000, cp_next[15:12]};
            bundle_o.data[1] = Utf8Cont | {2'b00, cp_next[11:6] & Utf8ContMask};
            bundle_o.data[2] = Utf8Cont | {2'b00, cp_next[5:0] & Utf8ContMask};
            bundle_o.n_data  = 2'd3;
          end
        end
      end
      default: begin
        bundle_o = '0;
      end
    endcase
    // A source that ends inside the string reports it after any data.
    if (src_end && open) begin
      bundle_o.has_tail  = 1'b1;
      bundle_o.tail_kind = KIND_UNTERM;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      hex_count_q  <= '0;
      code_point_q <= '0;
      byte_count_q <= '0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      hex_count_q  <= hex_count_d;
      code_point_q <= code_point_d;
      byte_count_q <= byte_count_d;
    end
  end

endmodule

/* hw/rtl/jsu_result_queue.sv */
// Two-entry bundle buffer that hands out the results one word at a time.
module jsu_result_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  jsu_pkg::bundle_t   bundle_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               ready_i,
  output jsu_pkg::out_word_t word_o
);
  import jsu_pkg::*;

  bundle_t    slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q, fill_d;
  logic [1:0] idx_q, idx_d;
  bundle_t    head;
  logic [2:0] len;
  logic       is_last;
  logic       take;
  logic       pop;

  // Head bundle and the position of the word within it.
  assign head    = slot_q[rd_ptr_q];
  assign len     = bundle_len(head);
  assign is_last = ({1'b0, idx_q} == (len - 3'd1));
  assign valid_o = (fill_q != 2'd0);
  assign full_o  = (fill_q == 2'd2);
  assign take    = valid_o && ready_i;
  assign pop     = take && is_last;

  // Output word selection: data bytes, then the closing word.
  always_comb begin
    word_o          = '0;
    word_o.last     = is_last;
    if (idx_q < head.n_data) begin
      word_o.kind = KIND_DATA;
      case (idx_q)
        2'd0:    word_o.out_byte = head.data[0];
        2'd1:    word_o.out_byte = head.data[1];
        2'd2:    word_o.out_byte = head.data[2];
        default: word_o.out_byte = '0;
      endcase
    end else begin
      word_o.kind     = head.tail_kind;
      word_o.consumed = head.consumed;
    end
  end

  // Fill level and word index updates.
  always_comb begin
    fill_d = fill_q + {1'b0, push_i} - {1'b0, pop};
    idx_d  = idx_q;
    if (take) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
      idx_q    <= '0;
    end else begin
      fill_q <= fill_d;
      idx_q  <= idx_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // Bundle storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= bundle_i;
    end
  end

endmodule

/* hw/rtl/json_string_unescape_unit.sv */
// Top level of the JSON string unescape unit.
//
//   Channel  Direction  Word per handshake
//   in_if    sink       one source byte with its end flag
//   out_if   source     one decoded byte, done marker or error
//
// One source byte is accepted per cycle. A byte that yields several words
// (up to three UTF-8 bytes plus a closing word) hands them out one word at
// a time; the two-entry result buffer sets how far input can run ahead.
// Reset returns the parser to waiting for the opening quote and empties
// the buffer. Input stalls only while both buffer entries hold results.
module json_string_unescape_unit #(
  parameter int unsigned COUNT_WIDTH = jsu_pkg::CountWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  jsu_stream_if.sink          in_if,
  jsu_stream_if.source        out_if
);
  import jsu_pkg::*;

  logic    accept;
  logic    push;
  logic    full;
  bundle_t bundle;

  // Input handshake.
  assign in_if.ready = !full;
  assign accept      = in_if.valid && in_if.ready;
  assign push        = accept && (bundle_len(bundle) != 3'd0);

  // Byte decoder.
  jsu_decoder #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_decoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .word_i   (in_if.data),
    .bundle_o (bundle)
  );

  // Result buffer and serializer.
  jsu_result_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .full_o   (full),
    .valid_o  (out_if.valid),
    .ready_i  (out_if.ready),
    .word_o   (out_if.data)
  );

endmodule

/* hw/rtl/jsu_checker.sv */
// Port-level assertions of the JSON string unescape unit and their binding.
`include "json_string_unescape_unit_assert.svh"

module jsu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input jsu_pkg::out_word_t out_word_i
);
  import jsu_pkg::*;

  // A word that is offered stays offered until it is taken.
  `JSU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "output word withdrawn")

  // A done marker or an error always closes the results of its byte.
  `JSU_ASSERT_IMPL(a_tail_last, clk_i, rst_ni, out_valid_i && (out_word_i.kind != KIND_DATA), out_word_i.last, "closing word not marked last")

  // Only a done marker carries a length.
  `JSU_ASSERT_IMPL(a_consumed_zero, clk_i, rst_ni, out_valid_i && (out_word_i.kind != KIND_DONE), out_word_i.consumed == '0, "length outside done word")

  // Input is held off only while results are waiting.
  `JSU_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !in_ready_i, out_valid_i, "input stalled with no pending output")

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_word_i  (out_if.data)
);
